FILE: src/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 block.
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;     // write byte_val at the current block position
    logic [7:0] byte_val;
    logic [5:0] byte_pos;
    logic       count_inc;    // advance the byte count
    logic       clear_tail;   // zero the words after the padding byte's word
    logic       clear_all;    // zero the whole block
    logic       put_length;   // write the bit length into words 14 and 15
    logic       start;        // load schedule and working variables
    logic       round;        // run one round
    logic [5:0] round_idx;
    logic       finish;       // add working variables into the hash
    logic       restart;      // initial hash values, zero count
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] count_low;    // byte count modulo 64
  } sha_stat_t;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage
`default_nettype wire

FILE: src/sha_datapath.sv
// Block buffer, message schedule, round logic, hash words and byte count.
`default_nettype none
module sha_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sha_pkg::sha_cmd_t cmd,
  input  wire logic [2:0]        out_sel,
  output      sha_pkg::sha_stat_t stat,
  output      logic [31:0]       hash_out
);
  import sha_pkg::*;

  logic [31:0] block_words [16];
  logic [31:0] sched [16];
  logic [31:0] hash_words [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [60:0] byte_count;

  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [63:0] bits;
  logic [31:0] w, w2, w7, w15, w16, s0, s1, t1, t2;
  logic [3:0]  ri;

  assign wi = cmd.byte_pos[5:2];
  assign sh = 5'd24 - {cmd.byte_pos[1:0], 3'b000};
  assign bits = {byte_count, 3'b000};
  assign ri = cmd.round_idx[3:0];

  always_comb begin
    w2  = sched[4'(ri - 4'd2)];
    w7  = sched[4'(ri - 4'd7)];
    w15 = sched[4'(ri - 4'd15)];
    w16 = sched[ri];
    s1 = rotr(w2, 5'd17) ^ rotr(w2, 5'd19) ^ (w2 >> 10);
    s0 = rotr(w15, 5'd7) ^ rotr(w15, 5'd18) ^ (w15 >> 3);
    if (cmd.round_idx < 6'd16) begin
      w = w16;
    end else begin
      w = s1 + w7 + s0 + w16;
    end
    t1 = h + (rotr(e, 5'd6) ^ rotr(e, 5'd11) ^ rotr(e, 5'd25))
       + ((e & f) ^ (~e & g)) + RoundK[cmd.round_idx] + w;
    t2 = (rotr(a, 5'd2) ^ rotr(a, 5'd13) ^ rotr(a, 5'd22))
       + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    // Each block word takes at most one update per cycle.
    for (int i = 0; i < 16; i++) begin
      if (cmd.put_length && i >= 14) begin
        block_words[i] <= (i == 14) ? bits[63:32] : bits[31:0];
      end else if (cmd.clear_all || (cmd.clear_tail && 4'(i) > wi)) begin
        block_words[i] <= '0;
      end else if (cmd.put_byte && 4'(i) == wi) begin
        if (cmd.byte_pos[1:0] == 2'd0) begin
          block_words[i] <= {cmd.byte_val, 24'd0};
        end else begin
          block_words[i] <= block_words[i] | ({24'd0, cmd.byte_val} << sh);
        end
      end
    end
    if (cmd.start) begin
      for (int i = 0; i < 16; i++) sched[i] <= block_words[i];
      a <= hash_words[0]; b <= hash_words[1]; c <= hash_words[2]; d <= hash_words[3];
      e <= hash_words[4]; f <= hash_words[5]; g <= hash_words[6]; h <= hash_words[7];
    end
    if (cmd.round) begin
      sched[ri] <= w;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) hash_words[i] <= HashInit[i];
      byte_count <= '0;
    end else begin
      if (cmd.finish) begin
        hash_words[0] <= hash_words[0] + a; hash_words[1] <= hash_words[1] + b;
        hash_words[2] <= hash_words[2] + c; hash_words[3] <= hash_words[3] + d;
        hash_words[4] <= hash_words[4] + e; hash_words[5] <= hash_words[5] + f;
        hash_words[6] <= hash_words[6] + g; hash_words[7] <= hash_words[7] + h;
      end
      if (cmd.count_inc) byte_count <= byte_count + 61'd1;
    end
  end

  assign stat.count_low = byte_count[5:0];
  assign hash_out = hash_words[out_sel];

endmodule
`default_nettype wire

FILE: src/sha_control.sv
// Sequencer for byte intake, padding, compression rounds and digest output.
`default_nettype none
module sha_control (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire sha_pkg::sha_in_t   in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      sha_pkg::sha_out_t  out_data,
  input  wire logic [31:0]        hash_out,
  output      logic [2:0]         out_sel,
  input  wire sha_pkg::sha_stat_t stat,
  output      sha_pkg::sha_cmd_t  cmd
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPad    = 3'd1;
  localparam logic [2:0] StStart  = 3'd2;
  localparam logic [2:0] StRound  = 3'd3;
  localparam logic [2:0] StFinish = 3'd4;
  localparam logic [2:0] StEmit   = 3'd5;
  localparam logic [2:0] StLen    = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] round_idx, round_idx_next;
  logic       ending, ending_next;     // end of message pending
  logic       final_blk, final_blk_next; // block being hashed carries the length
  logic [2:0] word_idx, word_idx_next;
  // Set when the padding byte landed too late for the length to fit.
  logic       pad_overflow, pad_overflow_next;
  logic       accept;

  assign in_stall = (state != StIdle);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state == StEmit);
  assign out_sel = word_idx;
  assign out_data.digest_word = hash_out;
  assign out_data.word_index = word_idx;
  assign out_data.last_word = (word_idx == 3'd7);

  always_comb begin
    cmd = '0;
    cmd.round_idx = round_idx;
    cmd.byte_pos = stat.count_low;
    state_next = state;
    round_idx_next = round_idx;
    ending_next = ending;
    final_blk_next = final_blk;
    word_idx_next = word_idx;
    unique case (state)
      StIdle: begin
        if (accept) begin
          ending_next = in_data.end_of_message;
          final_blk_next = 1'b0;
          if (in_data.byte_present) begin
            cmd.put_byte = 1'b1;
            cmd.byte_val = in_data.message_byte;
            cmd.count_inc = 1'b1;
            if (stat.count_low == 6'd63) state_next = StStart;
            else if (in_data.end_of_message) state_next = StPad;
          end else if (in_data.end_of_message) begin
            state_next = StPad;
          end
        end
      end
      StPad: begin
        cmd.put_byte = 1'b1;
        cmd.byte_val = PadByte;
        cmd.clear_tail = 1'b1;
        ending_next = 1'b0;
        if (stat.count_low < 6'd56) begin
          cmd.put_length = 1'b1;
          final_blk_next = 1'b1;
        end
        state_next = StStart;
      end
      StStart: begin
        cmd.start = 1'b1;
        round_idx_next = '0;
        state_next = StRound;
      end
      StRound: begin
        cmd.round = 1'b1;
        round_idx_next = round_idx + 6'd1;
        if (round_idx == 6'd63) state_next = StFinish;
      end
      StFinish: begin
        cmd.finish = 1'b1;
        if (ending) begin
          state_next = StPad;
        end else if (final_blk) begin
          word_idx_next = '0;
          state_next = StEmit;
        end else if (pad_overflow) begin
          // A padding block that overflowed needs a second block with the length.
          cmd.clear_all = 1'b1;
          state_next = StLen;
        end else begin
          state_next = StIdle;
        end
      end
      StLen: begin
        cmd.put_length = 1'b1;
        final_blk_next = 1'b1;
        state_next = StStart;
      end
      StEmit: begin
        if (!out_stall) begin
          word_idx_next = word_idx + 3'd1;
          if (word_idx == 3'd7) begin
            cmd.restart = 1'b1;
            state_next = StIdle;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_comb begin
    pad_overflow_next = pad_overflow;
    if (state == StPad) pad_overflow_next = (stat.count_low >= 6'd56);
    else if (state == StLen) pad_overflow_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      round_idx <= '0;
      ending <= 1'b0;
      final_blk <= 1'b0;
      word_idx <= '0;
      pad_overflow <= 1'b0;
    end else begin
      state <= state_next;
      round_idx <= round_idx_next;
      ending <= ending_next;
      final_blk <= final_blk_next;
      word_idx <= word_idx_next;
      pad_overflow <= pad_overflow_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/sha256_message_digest.sv
// Top level of the streaming SHA-256 digest block.
// A byte that does not fill a block is taken while the sequencer stays idle; a
// block-filling byte starts a compression (load, 64 rounds, hash update) on
// the single round unit, and input stalls until it ends. An end transfer adds
// one or two such compressions plus the padding steps, then eight digest transfers,
// one per cycle while the output is not stalled. Synchronous reset loads the
// initial hash values, clears the byte count and returns the sequencer to idle.
`default_nettype none
module sha256_message_digest (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire sha_pkg::sha_in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  // Command and status links between the sequencer and the datapath.
  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [2:0]  out_sel;
  logic [31:0] hash_out;

  // The sequencer takes one input transfer at a time and holds stall high
  // while compressing, padding or presenting the digest words.
  sha_control u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .hash_out, .out_sel, .stat, .cmd
  );

  // The datapath holds the block buffer, schedule window, round variables,
  // hash words and byte count, all driven by the sequencer's commands.
  sha_datapath u_dp (
    .clk, .rst, .cmd, .out_sel, .stat, .hash_out
  );

endmodule
`default_nettype wire

FILE: src/sha_checker.sv
// Port-level checks for the SHA-256 digest block, bound to the top level.
`default_nettype none
module sha_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sha_pkg::sha_out_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while digest shown");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest changed");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag mismatch");
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest words out of order");
endmodule

bind sha256_message_digest sha_checker u_sha_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
